>>> src/sha256_pkg.sv
// package for the sha-256 stream hasher: widths, init values, round constants
// and round helper functions; no dependencies
`timescale 1ns / 1ps
package sha256_pkg;

   localparam int WordWidth  = 32;

   typedef logic [WordWidth-1:0] word_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       load_byte;   // store req byte at fill position
      logic       start_block; // copy chaining words into working vars
      logic       round;       // one compression round
      logic       finish;      // add working vars into chaining words
      logic       restart;     // chaining words to initial values, counters cleared
      logic [1:0] src;         // block source for schedule words
      logic [5:0] rnd;         // round number
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [5:0] fill;
   } dp_stat_type;

   localparam logic [1:0] SrcBuf   = 2'd0; // full buffer
   localparam logic [1:0] SrcPad   = 2'd1; // buffer + 0x80 + length
   localparam logic [1:0] SrcPadNl = 2'd2; // buffer + 0x80, no length
   localparam logic [1:0] SrcLen   = 2'd3; // zeros + length

   function automatic word_type init_word(input logic [2:0] i);
      word_type r;
      case (i)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (WordWidth - n));
   endfunction

endpackage

>>> src/sha256_dp.sv
// sha-256 datapath: length counter, message schedule window (which also
// collects the block bytes), working variables and chaining words; uses sha256_pkg
`timescale 1ns / 1ps
module sha256_dp
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   input  logic [7:0]  req_data_byte,
   input  logic [2:0]  out_sel,
   output dp_stat_type stat,
   output word_type    out_word
);

   logic [5:0]  fill_ff, fill_in;
   logic [60:0] count_ff, count_in;
   word_type    h_ff [8];
   word_type    v_ff [8];
   word_type    w_ff [16];
   logic [63:0] bits;
   word_type    blk_word;
   word_type    part_word;
   word_type    w_cur, w_new, t1, t2, s0, s1, e, a;

   assign stat.fill = fill_ff;
   assign out_word  = h_ff[out_sel];
   assign bits      = {count_ff, 3'b000};

   // block word for the first 16 rounds; window slot 0 holds stored word rnd
   always_comb begin
      // partly filled word: stored bytes, then the 0x80 pad, then zeros
      for (int j = 0; j < 4; j++) begin
         if (j < int'(fill_ff[1:0])) part_word[8*(3-j) +: 8] = w_ff[0][8*(3-j) +: 8];
         else if (j == int'(fill_ff[1:0])) part_word[8*(3-j) +: 8] = 8'h80;
         else part_word[8*(3-j) +: 8] = 8'h00;
      end
      case (cmd.src)
         SrcBuf: blk_word = w_ff[0];
         SrcPad, SrcPadNl: begin
            if (cmd.rnd[3:0] < fill_ff[5:2]) blk_word = w_ff[0];
            else if (cmd.rnd[3:0] == fill_ff[5:2]) blk_word = part_word;
            else blk_word = '0;
         end
         default: blk_word = '0;
      endcase
      // bit length in the last two words
      if (cmd.src == SrcPad || cmd.src == SrcLen) begin
         if (cmd.rnd[3:0] == 4'd14) blk_word = bits[63:32];
         else if (cmd.rnd[3:0] == 4'd15) blk_word = bits[31:0];
      end
   end

   // schedule expansion on a 16-word sliding window
   always_comb begin
      s0    = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1    = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
      w_cur = (cmd.rnd < 6'd16) ? blk_word : w_new;
      e  = v_ff[4];
      a  = v_ff[0];
      t1 = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
           ((e & v_ff[5]) ^ (~e & v_ff[6])) + RoundK[cmd.rnd] + w_cur;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
           ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   // fill and byte count
   always_comb begin
      fill_in  = fill_ff;
      count_in = count_ff;
      if (cmd.load_byte) begin
         fill_in  = fill_ff + 6'd1;
         count_in = count_ff + 61'd1;
      end
      if (cmd.restart) begin
         fill_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   // byte intake into the window, schedule shift and working variables
   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         w_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= req_data_byte;
      end else if (cmd.start_block) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (cmd.round) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_cur;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   // chaining words
   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= init_word(3'(i));
      end else if (cmd.finish) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
      end
   end

endmodule

>>> src/sha256_ctrl.sv
// sha-256 controller: sequences byte intake, compressions, padding and
// digest output; uses sha256_pkg
`timescale 1ns / 1ps
module sha256_ctrl
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  out_sel,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StStart = 3'd1;
   localparam logic [2:0] StRound = 3'd2;
   localparam logic [2:0] StFin   = 3'd3;
   localparam logic [2:0] StOut   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [5:0] rnd_ff, rnd_in;
   logic [1:0] src_ff, src_in;
   logic       pend_ff, pend_in;   // digest pending after this block
   logic       two_ff, two_in;     // length block still to follow
   logic [2:0] idx_ff, idx_in;
   logic       take;

   assign req_stall = (state_ff != StIdle);
   assign take      = req_valid && !req_stall;
   assign rsp_valid = (state_ff == StOut);
   assign out_sel   = idx_ff;

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      src_in   = src_ff;
      pend_in  = pend_ff;
      two_in   = two_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.src  = src_ff;
      cmd.rnd  = rnd_ff;
      case (state_ff)
         StIdle: begin
            if (take) begin
               cmd.load_byte = req_byte_present;
               if (req_byte_present && stat.fill == 6'd63) begin
                  src_in   = SrcBuf;
                  pend_in  = req_end_of_message;
                  two_in   = 1'b0;
                  state_in = StStart;
               end else if (req_end_of_message) begin
                  // fill after this item's byte decides one or two blocks
                  pend_in  = 1'b1;
                  two_in   = 1'b0;
                  state_in = StStart;
                  if ((req_byte_present ? stat.fill + 6'd1 : stat.fill) >= 6'd56) begin
                     src_in = SrcPadNl;
                     two_in = 1'b1;
                  end else begin
                     src_in = SrcPad;
                  end
               end
            end
         end
         StStart: begin
            cmd.start_block = 1'b1;
            rnd_in   = '0;
            state_in = StRound;
         end
         StRound: begin
            cmd.round = 1'b1;
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = StFin;
         end
         StFin: begin
            cmd.finish = 1'b1;
            if (src_ff == SrcBuf && pend_ff) begin
               // full block at end of message: pad block follows, fill is zero
               src_in   = SrcPad;
               state_in = StStart;
            end else if (two_ff) begin
               two_in   = 1'b0;
               src_in   = SrcLen;
               state_in = StStart;
            end else if (pend_ff) begin
               idx_in   = '0;
               state_in = StOut;
            end else begin
               state_in = StIdle;
            end
         end
         StOut: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.restart = 1'b1;
                  pend_in     = 1'b0;
                  state_in    = StIdle;
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         pend_ff  <= 1'b0;
         two_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         two_ff   <= two_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff <= rnd_in;
      src_ff <= src_in;
   end

endmodule

>>> src/sha256_stream_hasher_core.sv
// top level of the sha-256 stream hasher; joins sha256_ctrl and sha256_dp
// uses sha256_pkg
`timescale 1ns / 1ps
// Byte-serial SHA-256. An item carrying a byte that does not complete a
// 64-byte block is taken without a stall. A byte that completes a block holds
// the input while one shared round unit runs the 64 rounds.
// An end-of-message item runs one or two padding compressions and then
// offers eight digest words, index 0 first, one per cycle when not stalled;
// the last has rsp_last_word set. After the eighth word the hasher is back
// at its initial state for the next message.
module sha256_stream_hasher_core
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic [2:0]  sel;

   sha256_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_byte_present, .req_end_of_message,
      .req_stall, .rsp_valid, .rsp_stall, .out_sel(sel), .stat, .cmd
   );

   sha256_dp u_dp (
      .clock, .reset, .cmd, .req_data_byte, .out_sel(sel), .stat,
      .out_word(rsp_digest_word)
   );

   assign rsp_word_index = sel;
   assign rsp_last_word  = (sel == 3'd7);

endmodule

>>> bench/tb_sha256_stream_hasher_core.sv
// testbench for sha256_stream_hasher_core: random and directed byte streams,
// digests predicted by an in-bench sha-256 model; uses sha256_pkg and the rtl
`timescale 1ns / 1ps
module tb_sha256_stream_hasher_core;
   import sha256_pkg::*;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } byte_item_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_out_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_byte_present;
   logic        req_end_of_message;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   byte_item_type  pending_bytes[$];
   digest_out_type digest_queue[$];
   int             mismatch_count;
   int             burst_left;
   int             gap_left;
   int             stall_phase;

   // predictor state
   word_type    hash_state [8];
   logic [7:0]  msg_block [64];
   logic [6:0]  fill_count;
   logic [60:0] byte_total;

   sha256_stream_hasher_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_data_byte(req_data_byte), .req_byte_present(req_byte_present),
      .req_end_of_message(req_end_of_message),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word)
   );

   always #4 clock = ~clock;

   function automatic word_type ror32(word_type x, int n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type init_value(int i);
      word_type iv [8];
      iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      init_value = iv[i];
   endfunction

   task automatic compress_block(input logic [7:0] blk [64]);
      word_type sched [64];
      word_type v [8];
      word_type s0, s1, t1, t2;
      for (int i = 0; i < 16; i++)
         sched[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
         s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
         sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
      end
      v = hash_state;
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + sched[i];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endtask

   task automatic restart_hash();
      for (int i = 0; i < 8; i++) hash_state[i] = init_value(i);
      fill_count = '0;
      byte_total = '0;
   endtask

   // expected digest words for one accepted word
   task automatic predict_digest(input byte_item_type it);
      logic [7:0]  tail [64];
      logic [63:0] bit_len;
      digest_out_type d;
      if (it.byte_present) begin
         msg_block[fill_count[5:0]] = it.data_byte;
         fill_count = fill_count + 7'd1;
         byte_total = byte_total + 61'd1;
         if (fill_count >= 64) begin
            compress_block(msg_block);
            fill_count = '0;
         end
      end
      if (it.end_of_message) begin
         for (int i = 0; i < 64; i++) tail[i] = (i < fill_count) ? msg_block[i] : 8'h00;
         tail[fill_count[5:0]] = 8'h80;
         if (fill_count >= 56) begin
            compress_block(tail);
            for (int i = 0; i < 64; i++) tail[i] = 8'h00;
         end
         bit_len = {byte_total, 3'b000};
         for (int i = 0; i < 8; i++) tail[56+i] = bit_len[63-8*i -: 8];
         compress_block(tail);
         for (int i = 0; i < 8; i++) begin
            d.digest_word = hash_state[i];
            d.word_index = 3'(i);
            d.last_word = (i == 7);
            digest_queue.push_back(d);
         end
         restart_hash();
      end
   endtask

   function automatic byte_item_type make_word(logic [7:0] b, logic p, logic e);
      make_word.data_byte = b;
      make_word.byte_present = p;
      make_word.end_of_message = e;
   endfunction

   task automatic queue_message(int len, bit noise);
      for (int i = 0; i < len; i++) begin
         if (noise && $urandom_range(0, 9) == 0)
            pending_bytes.push_back(make_word(8'($urandom_range(0, 255)), 1'b0, 1'b0));
         pending_bytes.push_back(make_word(8'($urandom_range(0, 255)), 1'b1,
                                 (i == len - 1) && $urandom_range(0, 1)));
      end
      if (len == 0 || pending_bytes[$].end_of_message == 1'b0)
         pending_bytes.push_back(make_word(8'($urandom_range(0, 255)), 1'b0, 1'b1));
   endtask

   // driver: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            predict_digest(make_word(req_data_byte, req_byte_present, req_end_of_message));
            void'(pending_bytes.pop_front());
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0 && burst_left > 0) begin
            req_valid <= 1'b1;
            {req_data_byte, req_byte_present, req_end_of_message} <= pending_bytes[0];
            burst_left <= burst_left - 1;
         end else begin
            req_valid <= 1'b0;
            burst_left <= $urandom_range(1, 40);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
         end
      end
   end

   // monitor and receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_phase <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected digest word %h index %0d", rsp_digest_word,
                           rsp_word_index);
            end else begin
               digest_out_type e;
               e = digest_queue.pop_front();
               if (e !== {rsp_digest_word, rsp_word_index, rsp_last_word}) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("digest mismatch exp %h/%0d/%b got %h/%0d/%b",
                              e.digest_word, e.word_index, e.last_word,
                              rsp_digest_word, rsp_word_index, rsp_last_word);
               end
            end
         end
         stall_phase <= (stall_phase + 1) % 300;
         rsp_stall <= (stall_phase < 100) ? 1'b0 : ($urandom_range(0, 2) == 0);
      end
   end

   initial begin
      int len;
      clock = 0;
      reset = 1;
      req_valid = 0;
      req_data_byte = 0;
      req_byte_present = 0;
      req_end_of_message = 0;
      rsp_stall = 0;
      mismatch_count = 0;
      restart_hash();
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
      // directed: empty message, extreme bytes, pad boundary lengths
      pending_bytes.push_back(make_word(8'h00, 1'b0, 1'b0));
      pending_bytes.push_back(make_word(8'hff, 1'b0, 1'b1));
      pending_bytes.push_back(make_word(8'hff, 1'b1, 1'b1));
      pending_bytes.push_back(make_word(8'h00, 1'b1, 1'b0));
      pending_bytes.push_back(make_word(8'haa, 1'b1, 1'b0));
      pending_bytes.push_back(make_word(8'h55, 1'b0, 1'b0));
      pending_bytes.push_back(make_word(8'h00, 1'b1, 1'b1));
      queue_message(55, 0);
      queue_message(56, 0);
      queue_message(63, 0);
      queue_message(64, 0);
      // random messages, mostly short
      for (int n = 0; n < 15; n++) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 12);
         queue_message(len, 1);
      end
      repeat (5) @(posedge clock);
      reset <= 0;
      wait (pending_bytes.size() == 0 && !req_valid);
      wait (digest_queue.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && digest_queue.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule

>>> filelist.f
src/sha256_pkg.sv
src/sha256_dp.sv
src/sha256_ctrl.sv
src/sha256_stream_hasher_core.sv
bench/tb_sha256_stream_hasher_core.sv
